// ===== rtl/cia_pkg.sv =====
// Shared opcodes, widths and limits for the checked integer ALU.
package cia_pkg;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned DATA_W = 32;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_NEG = 3'd4;
	localparam logic [OP_W-1:0] OP_EQ  = 3'd5;

	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef logic [OP_W-1:0]          opcode_t;
	typedef logic signed [DATA_W-1:0] word_t;
endpackage

// ===== rtl/cia_if.sv =====
// Valid/ready channel interfaces for ALU requests and responses.
interface cia_req_if;
	import cia_pkg::*;
	logic    valid;
	logic    ready;
	opcode_t opcode;
	word_t   operand_a;
	word_t   operand_b;
	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

interface cia_rsp_if;
	import cia_pkg::*;
	logic  valid;
	logic  ready;
	word_t result_value;
	logic  overflow_flag;
	logic  div_zero_flag;
	modport source (output valid, output result_value, output overflow_flag,
		output div_zero_flag, input ready);
	modport sink (input valid, input result_value, input overflow_flag,
		input div_zero_flag, output ready);
endinterface

// ===== rtl/checked_int32_alu.sv =====
// Top level of the checked signed 32-bit ALU.
// Usage:
//   req channel carries opcode, operand_a and operand_b; rsp channel returns
//   result_value, overflow_flag and div_zero_flag, one response per request,
//   in request order. A transaction completes when valid and ready are high.
//   Opcodes: add, subtract, multiply, divide, negate a, equal.
// Pipeline: every opcode takes the same path from request acceptance to response
//   valid. All operations travel one pipeline whose depth is set by the
//   restoring divider, which retires one quotient bit per stage (32 stages),
//   plus an operand stage, a checking stage and the output register.
// Throughput: one transaction per cycle while no output stall holds the pipeline.
// Stall: while a response waits on rsp.ready the whole pipeline holds and
//   req.ready drops; nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty and
//   ready.
module checked_int32_alu (
	input  logic clk,
	input  logic arst_n,
	cia_req_if.sink   req,
	cia_rsp_if.source rsp
);
	import cia_pkg::*;

	localparam int unsigned STEPS = DATA_W;

	logic en;

	// operand stage
	logic                  vld_s1;
	opcode_t               op_s1;
	word_t                 a_s1;
	word_t                 b_s1;
	logic signed [63:0]    prod_s1;
	logic [DATA_W:0]       sum_s1;
	logic [DATA_W:0]       diff_s1;

	// divider stages, index 0 is the checking stage
	logic                  vld_s  [0:STEPS];
	logic                  isdiv_s[0:STEPS];
	logic                  qneg_s [0:STEPS];
	logic                  ovf_s  [0:STEPS];
	logic                  dz_s   [0:STEPS];
	word_t                 misc_s [0:STEPS];
	logic [DATA_W-1:0]     rem_s  [0:STEPS];
	logic [DATA_W-1:0]     num_s  [0:STEPS];
	logic [DATA_W-1:0]     den_s  [0:STEPS];

	logic                  out_vld_q;
	word_t                 out_res_q;
	logic                  out_ovf_q;
	logic                  out_dz_q;

	word_t                 misc_c;
	logic                  ovf_c;
	logic                  dz_c;
	logic [DATA_W-1:0]     quo_c;
	word_t                 fin_res_c;

	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= req.opcode;
			a_s1    <= req.operand_a;
			b_s1    <= req.operand_b;
			prod_s1 <= 64'(req.operand_a) * 64'(req.operand_b);
			sum_s1  <= {req.operand_a[DATA_W-1], req.operand_a}
				+ {req.operand_b[DATA_W-1], req.operand_b};
			diff_s1 <= {req.operand_a[DATA_W-1], req.operand_a}
				- {req.operand_b[DATA_W-1], req.operand_b};
		end
	end

	// range checks and results of everything but divide
	always_comb begin
		misc_c = '0;
		ovf_c  = 1'b0;
		dz_c   = 1'b0;
		case (op_s1)
			OP_ADD: begin
				if (sum_s1[DATA_W] != sum_s1[DATA_W-1]) ovf_c = 1'b1;
				else misc_c = word_t'(sum_s1[DATA_W-1:0]);
			end
			OP_SUB: begin
				if (diff_s1[DATA_W] != diff_s1[DATA_W-1]) ovf_c = 1'b1;
				else misc_c = word_t'(diff_s1[DATA_W-1:0]);
			end
			OP_MUL: begin
				if (!((&prod_s1[63:DATA_W-1]) || !(|prod_s1[63:DATA_W-1]))) ovf_c = 1'b1;
				else misc_c = prod_s1[DATA_W-1:0];
			end
			OP_DIV: begin
				if (b_s1 == '0) dz_c = 1'b1;
				else if (a_s1 == WORD_MIN && b_s1 == -32'sd1) ovf_c = 1'b1;
			end
			OP_NEG: begin
				if (a_s1 == WORD_MIN) begin
					ovf_c  = 1'b1;
					misc_c = WORD_MAX;
				end else begin
					misc_c = -a_s1;
				end
			end
			OP_EQ: begin
				misc_c = (a_s1 == b_s1) ? 32'sd1 : 32'sd0;
			end
			default: begin
				misc_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			isdiv_s[0] <= (op_s1 == OP_DIV);
			qneg_s[0]  <= a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
			ovf_s[0]   <= ovf_c;
			dz_s[0]    <= dz_c;
			misc_s[0]  <= misc_c;
			rem_s[0]   <= '0;
			num_s[0]   <= a_s1[DATA_W-1] ? DATA_W'(-a_s1) : DATA_W'(a_s1);
			den_s[0]   <= b_s1[DATA_W-1] ? DATA_W'(-b_s1) : DATA_W'(b_s1);
		end
	end

	// one restoring step per stage; quotient bits shift into the dividend
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [DATA_W:0] trial;
		logic [DATA_W:0] sub;
		logic            ge;

		assign trial = {rem_s[k], num_s[k][DATA_W-1]};
		assign sub   = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				isdiv_s[k+1] <= isdiv_s[k];
				qneg_s[k+1]  <= qneg_s[k];
				ovf_s[k+1]   <= ovf_s[k];
				dz_s[k+1]    <= dz_s[k];
				misc_s[k+1]  <= misc_s[k];
				den_s[k+1]   <= den_s[k];
				rem_s[k+1]   <= ge ? sub[DATA_W-1:0] : trial[DATA_W-1:0];
				num_s[k+1]   <= {num_s[k][DATA_W-2:0], ge};
			end
		end
	end

	assign quo_c = num_s[STEPS];

	always_comb begin
		if (!isdiv_s[STEPS]) begin
			fin_res_c = misc_s[STEPS];
		end else if (ovf_s[STEPS] || dz_s[STEPS]) begin
			fin_res_c = '0;
		end else if (qneg_s[STEPS]) begin
			fin_res_c = word_t'(-quo_c);
		end else begin
			fin_res_c = word_t'(quo_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= fin_res_c;
			out_ovf_q <= ovf_s[STEPS];
			out_dz_q  <= dz_s[STEPS];
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.result_value  = out_res_q;
	assign rsp.overflow_flag = out_ovf_q;
	assign rsp.div_zero_flag = out_dz_q;

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_zero_flag |-> !rsp.overflow_flag && rsp.result_value == '0)
		else $error("divide by zero response carries a value or overflow");

	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.overflow_flag |-> rsp.result_value == '0
			|| rsp.result_value == WORD_MAX)
		else $error("overflow response carries an unexpected value");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> !vld_s1 || $stable(op_s1))
		else $error("operand stage moved during an output stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("request ready does not follow output stage occupancy");
endmodule

// ===== bench/checked_int32_alu_checker.sv =====
// Checker for the ALU: watches both channels, predicts each response and compares it.
`timescale 1ns / 100ps
module checked_int32_alu_checker
	import cia_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cia_req_if.sink req_mon,
	cia_rsp_if.sink rsp_mon,
	output int fail_count,
	output int pending_count
);
	typedef struct {
		word_t value;
		logic  ovf;
		logic  dz;
	} alu_answer_t;

	alu_answer_t answers_q[$];

	function automatic alu_answer_t compute_answer(opcode_t op, word_t a, word_t b);
		alu_answer_t ans;
		longint sa;
		longint sb;
		longint r;
		sa = a;
		sb = b;
		r = 0;
		ans.ovf = 1'b0;
		ans.dz = 1'b0;
		case (op)
			OP_ADD, OP_SUB, OP_MUL: begin
				if (op == OP_ADD) r = sa + sb;
				else if (op == OP_SUB) r = sa - sb;
				else r = sa * sb;
				if (r > longint'(WORD_MAX) || r < longint'(WORD_MIN)) begin
					r = 0;
					ans.ovf = 1'b1;
				end
			end
			OP_DIV: begin
				if (sb == 0) begin
					ans.dz = 1'b1;
				end else begin
					r = sa / sb;
					// only the most negative over minus one can escape the range
					if (r > longint'(WORD_MAX)) begin
						r = 0;
						ans.ovf = 1'b1;
					end
				end
			end
			OP_NEG: begin
				if (a == WORD_MIN) begin
					r = longint'(WORD_MAX);
					ans.ovf = 1'b1;
				end else begin
					r = -sa;
				end
			end
			OP_EQ: r = (a == b) ? 1 : 0;
			default: r = 0;
		endcase
		ans.value = word_t'(r);
		return ans;
	endfunction

	assign pending_count = answers_q.size();

	always @(posedge clk or negedge arst_n) begin
		alu_answer_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				answers_q.push_back(compute_answer(req_mon.opcode, req_mon.operand_a,
					req_mon.operand_b));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (answers_q.size() == 0) begin
					$display("%0t: response with nothing expected: value %0d ovf %b dz %b",
						$time, rsp_mon.result_value, rsp_mon.overflow_flag,
						rsp_mon.div_zero_flag);
					fail_count <= fail_count + 1;
				end else begin
					want = answers_q.pop_front();
					if (rsp_mon.result_value !== want.value || rsp_mon.overflow_flag !== want.ovf
						|| rsp_mon.div_zero_flag !== want.dz) begin
						$display("%0t: expected value %0d ovf %b dz %b, got value %0d ovf %b dz %b",
							$time, want.value, want.ovf, want.dz, rsp_mon.result_value,
							rsp_mon.overflow_flag, rsp_mon.div_zero_flag);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== bench/checked_int32_alu_tb.sv =====
// Top of the ALU testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 100ps
module checked_int32_alu_tb;
	import cia_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic recv_ready = 1'b0;
	int   fail_count;
	int   pending_count;
	int   send_idle_pct = 25;
	int   recv_idle_pct = 83;
	bit   hold_rsp = 1'b0;

	cia_req_if req ();
	cia_rsp_if rsp ();

	checked_int32_alu dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	checked_int32_alu_checker checker_i (.clk(clk), .arst_n(arst_n), .req_mon(req.sink),
		.rsp_mon(rsp.sink), .fail_count(fail_count), .pending_count(pending_count));

	always #10 clk = ~clk;

	assign rsp.ready = recv_ready;

	always @(posedge clk) begin
		if (hold_rsp) recv_ready <= 1'b0;
		else recv_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic word_t pick_operand();
		case ($urandom_range(9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return word_t'(32'sd0);
			3: return word_t'(-32'sd1);
			4: return word_t'($urandom_range(5));
			5: return word_t'($signed($urandom_range(65535)) - 32768);
			default: return word_t'($urandom);
		endcase
	endfunction

	// offer one transaction, idling at random first, and hold until it is taken
	task automatic send_op(opcode_t op, word_t a, word_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_random(int count);
		opcode_t op;
		for (int i = 0; i < count; i++) begin
			op = opcode_t'($urandom_range(7));
			if ($urandom_range(9) < 3) op = OP_DIV;
			send_op(op, pick_operand(), pick_operand());
		end
	endtask

	// wait for the last accepted transaction to be counted, then for all responses
	task automatic drain();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_ADD;
		req.operand_a = '0;
		req.operand_b = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_op(OP_ADD, WORD_MAX, word_t'(32'sd1));
		send_op(OP_ADD, WORD_MIN, word_t'(-32'sd1));
		send_op(OP_ADD, WORD_MAX, WORD_MIN);
		send_op(OP_SUB, WORD_MIN, word_t'(32'sd1));
		send_op(OP_SUB, word_t'(32'sd0), WORD_MIN);
		send_op(OP_SUB, word_t'(-32'sd1), WORD_MIN);
		send_op(OP_MUL, word_t'(32'sd65536), word_t'(32'sd65536));
		send_op(OP_MUL, WORD_MIN, word_t'(-32'sd1));
		send_op(OP_MUL, WORD_MIN, word_t'(32'sd1));
		send_op(OP_MUL, word_t'(-32'sd46341), word_t'(32'sd46340));
		send_op(OP_DIV, WORD_MIN, word_t'(-32'sd1));
		send_op(OP_DIV, word_t'(32'sd7), word_t'(32'sd0));
		send_op(OP_DIV, word_t'(-32'sd7), word_t'(32'sd2));
		send_op(OP_DIV, WORD_MAX, WORD_MIN);
		send_op(OP_DIV, WORD_MIN, WORD_MIN);
		send_op(OP_NEG, WORD_MIN, word_t'(32'sd5));
		send_op(OP_NEG, WORD_MAX, word_t'(-32'sd1));
		send_op(OP_NEG, word_t'(32'sd0), WORD_MAX);
		send_op(OP_EQ, WORD_MIN, WORD_MIN);
		send_op(OP_EQ, WORD_MIN, WORD_MAX);
		send_op(opcode_t'(3'd6), WORD_MAX, WORD_MAX);
		send_op(opcode_t'(3'd7), word_t'(-32'sd1), word_t'(-32'sd1));
		send_random(600);
		send_idle_pct = 83;
		recv_idle_pct = 25;
		send_random(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// hold off the receiver long enough for the pipeline to back up
		hold_rsp = 1'b1;
		fork
			begin
				repeat (120) @(posedge clk);
				hold_rsp = 1'b0;
			end
			begin
				send_random(80);
				req.valid <= 1'b0;
			end
		join
		drain();
		send_random(550);
		req.valid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("checked_int32_alu_tb passed");
		else $display("checked_int32_alu_tb failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("checked_int32_alu_tb failed");
		$finish;
	end
endmodule
